[design/alpha_outline_filter_assert.svh]
// assertion macros shared by the alpha outline filter modules
// expects signals clk and rst in the scope of each use
`ifndef ALPHA_OUTLINE_FILTER_ASSERT_SVH
`define ALPHA_OUTLINE_FILTER_ASSERT_SVH

// same-cycle implication, off during reset
`define AOF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define AOF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/aof_pkg.sv]
// shared types and constants of the alpha outline filter
// no dependencies
`default_nettype none

package aof_pkg;

  // configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTLINE_COLOR = 2'd2;

  localparam int DIM_BITS   = 13;
  localparam int PIXEL_BITS = 32;
  localparam int CHAN_BITS  = 8;

  localparam logic [DIM_BITS-1:0]   RESET_FRAME_WIDTH   = 13'd256;
  localparam logic [DIM_BITS-1:0]   RESET_FRAME_HEIGHT  = 13'd256;
  localparam logic [PIXEL_BITS-1:0] RESET_OUTLINE_COLOR = 32'd0;

  // input item kinds
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified item handed from front to back
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  opaque;
    logic                  emit;
    logic                  last;
    logic                  right_ok;
    logic                  below_ok;
    logic                  above_ok;
    logic                  left_ok;
  } aof_item_t;

endpackage

`default_nettype wire

[design/aof_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// read returns the old contents on a same-address write; no dependencies
`default_nettype none

module aof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/aof_queue.sv]
// small register queue that parts the front from the back
// no dependencies
`default_nettype none

module aof_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full      = (count == NW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/aof_front.sv]
// front of the outline filter: accepts items, tracks raster positions,
// classifies each item for the back; uses aof_pkg and the assertion header
`default_nettype none
`include "alpha_outline_filter_assert.svh"

module aof_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [aof_pkg::DIM_BITS-1:0] frame_width,
  input  wire logic [aof_pkg::DIM_BITS-1:0] frame_height,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [7:0]                   red,
  input  wire logic [7:0]                   green,
  input  wire logic [7:0]                   blue,
  input  wire logic [7:0]                   alpha,
  input  wire logic                         q_full,
  output logic                              push,
  output aof_pkg::aof_item_t                item,
  output logic      [CW-1:0]                col,
  output logic      [CW-1:0]                out_col
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int FW = $clog2(MAX_WIDTH + 2);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_column;
  logic [HW-1:0] out_row;
  logic [FW-1:0] fill_count;

  logic [31:0] width_raw;
  logic [31:0] height_raw;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [WW:0] w_ext;
  logic [WW:0] in_col_inc;
  logic [WW:0] out_col_inc;
  logic [RW:0] h_ext;
  logic [RW:0] in_row_ext;
  logic [RW:0] out_row_inc;
  logic is_flush;
  logic post_frame;
  logic accept;
  logic process;
  logic emit;
  logic in_wrap;
  logic out_wrap;
  logic rows_done;
  logic last;

  // live frame size, zero acts as one and oversize as the maximum
  assign width_raw  = 32'(frame_width);
  assign height_raw = 32'(frame_height);

  always_comb begin
    if (width_raw == 32'd0) begin
      w = WW'(1);
    end else if (width_raw > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_raw);
    end
    if (height_raw == 32'd0) begin
      h = HW'(1);
    end else if (height_raw > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_raw);
    end
  end

  // position arithmetic
  assign w_ext       = (WW + 1)'(w);
  assign in_col_inc  = (WW + 1)'(in_column) + (WW + 1)'(1);
  assign out_col_inc = (WW + 1)'(out_column) + (WW + 1)'(1);
  assign h_ext       = (RW + 1)'(h);
  assign in_row_ext  = (RW + 1)'(in_row);
  assign out_row_inc = (RW + 1)'(out_row) + (RW + 1)'(1);

  assign in_wrap   = (in_col_inc >= w_ext);
  assign out_wrap  = (out_col_inc >= w_ext);
  assign rows_done = (out_row_inc >= h_ext);

  // classification: pixels after the frame and flushes inside it are dropped
  assign is_flush   = (action == aof_pkg::ACTION_FLUSH);
  assign post_frame = (in_row_ext >= h_ext);
  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign process    = accept && (is_flush == post_frame);
  assign emit       = (fill_count >= (FW'(w) + FW'(1)));
  assign last       = emit && out_wrap && rows_done;

  // item for the back
  always_comb begin
    item.pixel    = is_flush ? '0 : {alpha, blue, green, red};
    item.opaque   = !is_flush && (alpha != 8'd0);
    item.emit     = emit;
    item.last     = last;
    item.right_ok = !out_wrap;
    item.below_ok = !rows_done;
    item.above_ok = (out_row != '0);
    item.left_ok  = (out_column != '0);
  end

  assign push    = process;
  assign col     = in_column;
  assign out_col = out_column;

  // raster counters, cleared after the last pixel of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      fill_count <= '0;
    end else if (process) begin
      if (last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        fill_count <= '0;
      end else begin
        if (in_wrap) begin
          in_column <= '0;
          in_row    <= in_row + RW'(1);
        end else begin
          in_column <= in_col_inc[CW-1:0];
        end
        if (emit) begin
          if (out_wrap) begin
            out_column <= '0;
            out_row    <= out_row + HW'(1);
          end else begin
            out_column <= out_col_inc[CW-1:0];
          end
        end else begin
          fill_count <= fill_count + FW'(1);
        end
      end
    end
  end

  // checks
  `AOF_ASSERT_NXT(a_frame_end_clears, process && last, in_column == '0 && in_row == '0 && fill_count == '0 && out_row == '0, "raster counters not cleared at frame end")
  `AOF_ASSERT_NXT(a_fill_step, process && !emit, fill_count == $past(fill_count) + FW'(1), "fill count did not step during warm-up")

endmodule

`default_nettype wire

[design/aof_back.sv]
// back of the outline filter: row memories, neighbour test, output register
// uses aof_pkg, aof_ram and the assertion header
`default_nettype none
`include "alpha_outline_filter_assert.svh"

module aof_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire aof_pkg::aof_item_t             q_item,
  input  wire logic [CW-1:0]                  q_col,
  input  wire logic [CW-1:0]                  q_out_col,
  output logic                                pop,
  input  wire logic [aof_pkg::PIXEL_BITS-1:0] outline_color,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [aof_pkg::PIXEL_BITS-1:0] out_pixel,
  output logic                                out_last
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // stage b holds the item whose row memory reads are in flight
  logic               b_valid;
  aof_pkg::aof_item_t b_item;
  logic [CW-1:0]      b_out_col;
  logic               fwd_valid;
  logic               fwd_opaque;

  logic [aof_pkg::PIXEL_BITS-1:0] held_pixel;
  logic                           prev_opaque;
  logic                           left_opaque;

  logic [aof_pkg::PIXEL_BITS-1:0] next_pixel;
  logic                           above_ram;
  logic                           above_wr;
  logic                           out_free;
  logic                           b_advance;
  logic                           self_opaque;
  logic                           above_opaque;
  logic                           touch;
  logic [aof_pkg::PIXEL_BITS-1:0] result;

  // flow control
  assign out_free  = !out_valid || !out_stall;
  assign b_advance = b_valid && (!b_item.emit || out_free);
  assign pop       = q_valid && (!b_valid || b_advance);
  assign above_wr  = b_advance && b_item.emit;

  // one row of pixels, read and rewritten at the input column
  aof_ram #(
    .WIDTH(aof_pkg::PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_delay_row (
    .clk    (clk),
    .wr_en  (pop),
    .wr_addr(q_col),
    .wr_data(q_item.pixel),
    .rd_en  (pop),
    .rd_addr(q_col),
    .rd_data(next_pixel)
  );

  // opacity of the row above, indexed by output column
  aof_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH)
  ) u_above_row (
    .clk    (clk),
    .wr_en  (above_wr),
    .wr_addr(b_out_col),
    .wr_data(self_opaque),
    .rd_en  (pop),
    .rd_addr(q_out_col),
    .rd_data(above_ram)
  );

  // neighbour test on the held pixel
  assign self_opaque  = (held_pixel[31:24] != 8'd0);
  assign above_opaque = fwd_valid ? fwd_opaque : above_ram;
  assign touch = (b_item.right_ok && (next_pixel[31:24] != 8'd0))
              || (b_item.below_ok && prev_opaque)
              || (b_item.above_ok && above_opaque)
              || (b_item.left_ok && left_opaque);
  assign result = (!self_opaque && touch) ? outline_color : held_pixel;

  // stage b occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  // stage b payload, with bypass when the above row is rewritten at once
  always_ff @(posedge clk) begin
    if (pop) begin
      b_item     <= q_item;
      b_out_col  <= q_out_col;
      fwd_valid  <= above_wr && (b_out_col == q_out_col);
      fwd_opaque <= self_opaque;
    end
  end

  // neighbourhood state carried between items
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel  <= '0;
      prev_opaque <= 1'b0;
      left_opaque <= 1'b0;
    end else if (b_advance) begin
      if (b_item.last) begin
        held_pixel  <= '0;
        prev_opaque <= 1'b0;
        left_opaque <= 1'b0;
      end else begin
        held_pixel  <= next_pixel;
        prev_opaque <= b_item.opaque;
        if (b_item.emit) begin
          left_opaque <= self_opaque;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (above_wr) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (above_wr) begin
      out_pixel <= result;
      out_last  <= b_item.last;
    end
  end

  // checks
  `AOF_ASSERT_IMP(a_out_from_stage, $rose(out_valid), $past(b_valid && b_item.emit), "result appeared without an item in stage b")
  `AOF_ASSERT_NXT(a_stage_holds, b_valid && b_item.emit && out_valid && out_stall, b_valid && b_item.emit && out_valid, "stage b lost its item under output stall")

endmodule

`default_nettype wire

[design/alpha_outline_filter.sv]
// alpha outline filter top level: configuration registers, front, queue, back
// uses aof_pkg, aof_front, aof_queue, aof_back (and aof_ram below it)
//
// Pixels of one image enter in raster order on the input channel (valid and
// stall, transfer when valid and not stall); action high marks a flush item.
// Each transfer of a pixel or of a flush after the frame gives the result of
// the pixel frame_width + 1 items earlier, so a frame of W by H pixels needs
// W + 1 flush items to drain; the final result carries frame_last.
// A result passes through the queue, stage b and the output register.
// With out_stall low one item per clock is sustained: each row memory takes
// one read and one write per cycle and the neighbour test is a single stage.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong to idle periods.
// Reset clears the raster counters and pipeline; the row memories keep
// undefined contents that go unused until the current frame writes them.
// When out_stall is held, up to four further items are taken (queue, stage
// and output register) before in_stall rises; nothing is lost or repeated.
`default_nettype none

module alpha_outline_filter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [aof_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [aof_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               action,
  input  wire logic [7:0]                         red,
  input  wire logic [7:0]                         green,
  input  wire logic [7:0]                         blue,
  input  wire logic [7:0]                         alpha,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [7:0]                         out_red,
  output logic      [7:0]                         out_green,
  output logic      [7:0]                         out_blue,
  output logic      [7:0]                         out_alpha,
  output logic                                    frame_last
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IW = $bits(aof_pkg::aof_item_t);
  localparam int QW = 2 * CW + IW;

  logic [aof_pkg::DIM_BITS-1:0]   frame_width;
  logic [aof_pkg::DIM_BITS-1:0]   frame_height;
  logic [aof_pkg::PIXEL_BITS-1:0] outline_color;

  logic               q_full;
  logic               push;
  aof_pkg::aof_item_t front_item;
  logic [CW-1:0]      front_col;
  logic [CW-1:0]      front_out_col;
  logic [QW-1:0]      push_data;
  logic               pop;
  logic               q_valid;
  logic [QW-1:0]      q_data;
  aof_pkg::aof_item_t q_item;
  logic [CW-1:0]      q_col;
  logic [CW-1:0]      q_out_col;
  logic [aof_pkg::PIXEL_BITS-1:0] out_pixel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= aof_pkg::RESET_FRAME_WIDTH;
      frame_height  <= aof_pkg::RESET_FRAME_HEIGHT;
      outline_color <= aof_pkg::RESET_OUTLINE_COLOR;
    end else if (cfg_write) begin
      case (cfg_index)
        aof_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[aof_pkg::DIM_BITS-1:0];
        aof_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[aof_pkg::DIM_BITS-1:0];
        aof_pkg::REG_OUTLINE_COLOR: outline_color <= cfg_data[aof_pkg::PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  aof_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .q_full      (q_full),
    .push        (push),
    .item        (front_item),
    .col         (front_col),
    .out_col     (front_out_col)
  );

  // queue between front and back
  assign push_data = {front_col, front_out_col, front_item};

  aof_queue #(
    .WIDTH(QW),
    .DEPTH(aof_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(q_valid),
    .pop_data (q_data)
  );

  assign q_col     = q_data[QW-1 -: CW];
  assign q_out_col = q_data[IW+CW-1 -: CW];
  assign q_item    = aof_pkg::aof_item_t'(q_data[IW-1:0]);

  // back: row memories and outline decision
  aof_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_col        (q_col),
    .q_out_col    (q_out_col),
    .pop          (pop),
    .outline_color(outline_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .out_last     (frame_last)
  );

  // unpack the result
  assign out_red   = out_pixel[7:0];
  assign out_green = out_pixel[15:8];
  assign out_blue  = out_pixel[23:16];
  assign out_alpha = out_pixel[31:24];

endmodule

`default_nettype wire

[verif/alpha_outline_checker.sv]
// checker for the alpha outline filter: follows register writes and both channels,
// predicts every filtered pixel and compares it field by field on each result transfer
// depends on aof_pkg
module alpha_outline_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [aof_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [aof_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               action,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic [7:0]                         alpha,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [7:0]                         out_red,
  input  logic [7:0]                         out_green,
  input  logic [7:0]                         out_blue,
  input  logic [7:0]                         out_alpha,
  input  logic                               frame_last,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 compared
);
  import aof_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } filtered_pixel_t;

  // live register copies
  logic [DIM_BITS-1:0]   width_reg;
  logic [DIM_BITS-1:0]   height_reg;
  logic [PIXEL_BITS-1:0] colour_reg;

  // one row of delayed pixels and the opacity of the row above the output
  logic [PIXEL_BITS-1:0] row_pixels [MAX_WIDTH];
  logic                  row_opaque [MAX_WIDTH];

  // raster position of the input and output sides
  int unsigned           in_col, in_row, out_col, out_row, fill;
  logic [PIXEL_BITS-1:0] held;
  logic                  prev_opaque, left_opaque;

  filtered_pixel_t       awaited_pixels [$];
  int                    errors = 0;
  int                    checks = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
  end

  // register value to dimension: zero acts as one, large values saturate
  function automatic int unsigned span(input logic [DIM_BITS-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic restart_raster();
    in_col      = 0;
    in_row      = 0;
    out_col     = 0;
    out_row     = 0;
    fill        = 0;
    held        = '0;
    prev_opaque = 1'b0;
    left_opaque = 1'b0;
  endtask

  // advance the raster by one input transfer, queueing the pixel it releases
  task automatic predict_outline(input logic is_flush, input logic [PIXEL_BITS-1:0] pix_in);
    int unsigned           w, h, col, oc;
    logic [PIXEL_BITS-1:0] pix, next_pix, res;
    logic                  opq, self_opq, touched, ends;
    filtered_pixel_t       due;
    w = span(width_reg, MAX_WIDTH);
    h = span(height_reg, MAX_HEIGHT);
    // flush before the frame is complete, or pixel while it drains: no effect
    if ((is_flush && in_row < h) || (!is_flush && in_row >= h)) return;
    pix = is_flush ? '0 : pix_in;
    opq = (pix[31:24] != 0);
    col = in_col % MAX_WIDTH;
    next_pix = row_pixels[col];
    row_pixels[col] = pix;
    ends = 1'b0;
    if (fill >= w + 1) begin
      // held pixel leaves, its neighbours are all known now
      oc = out_col % MAX_WIDTH;
      self_opq = (held[31:24] != 0);
      touched = ((out_col + 1 < w) && next_pix[31:24] != 0)
             || ((out_row + 1 < h) && prev_opaque)
             || ((out_row > 0) && row_opaque[oc])
             || ((out_col > 0) && left_opaque);
      res = (!self_opq && touched) ? colour_reg : held;
      ends = (out_row + 1 >= h) && (out_col + 1 >= w);
      due.red   = res[7:0];
      due.green = res[15:8];
      due.blue  = res[23:16];
      due.alpha = res[31:24];
      due.last  = ends;
      awaited_pixels.push_back(due);
      row_opaque[oc] = self_opq;
      left_opaque = self_opq;
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end else begin
      fill++;
    end
    held = next_pix;
    prev_opaque = opq;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (ends) restart_raster();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    filtered_pixel_t want;
    if (rst) begin
      width_reg  = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      colour_reg = RESET_OUTLINE_COLOR;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_pixels[i] = '0;
        row_opaque[i] = 1'b0;
      end
      restart_raster();
      awaited_pixels.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_pixels.size() == 0) begin
          errors++;
          $display("%0t: pixel expected none got %h %h %h %h last %b", $time,
                   out_red, out_green, out_blue, out_alpha, frame_last);
        end else begin
          want = awaited_pixels.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_alpha", want.alpha, out_alpha);
          check_field("frame_last", {7'd0, want.last}, {7'd0, frame_last});
          checks++;
        end
      end
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   width_reg  = cfg_data[DIM_BITS-1:0];
          REG_FRAME_HEIGHT:  height_reg = cfg_data[DIM_BITS-1:0];
          REG_OUTLINE_COLOR: colour_reg = cfg_data[PIXEL_BITS-1:0];
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && !in_stall) begin
        predict_outline(action == ACTION_FLUSH, {alpha, blue, green, red});
      end
    end
    mismatches  <= errors;
    outstanding <= awaited_pixels.size();
    compared    <= checks;
  end

endmodule

[verif/tb.sv]
// testbench top for the alpha outline filter: clock, reset, frame stimulus and verdict
// depends on aof_pkg, alpha_outline_filter and alpha_outline_checker
module tb;
  import aof_pkg::*;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int STEADY_FROM   = 1500;
  localparam int HOLD_FROM     = 300;
  localparam int LONG_HOLD     = 120;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      action    = ACTION_PIXEL;
  logic [7:0]                red       = '0;
  logic [7:0]                green     = '0;
  logic [7:0]                blue      = '0;
  logic [7:0]                alpha     = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall, out_valid, frame_last;
  logic [7:0]                out_red, out_green, out_blue, out_alpha;
  int                        mismatches, outstanding, compared;

  int          cycle_count  = 0;
  int          transfers    = 0;
  int          random_items = 0;
  int          frames       = 0;
  bit          steady       = 1'b0;
  bit          frame_gaps   = 1'b1;
  bit          mid_frame    = 1'b0;
  int unsigned densities [6] = '{0, 10, 30, 50, 80, 100};

  alpha_outline_filter #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dut (.*);

  alpha_outline_checker #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_checker (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: short stall bursts, quiet stretches and one long hold-off
  initial begin : result_stall
    bit held_off;
    held_off = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held_off && mid_frame && random_items >= HOLD_FROM) begin
        // long hold-off while pixels keep coming, so the filter backs up
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 39) == 0) begin
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end
    end
  end

  // one input transfer, with an optional gap ahead of it
  task automatic offer(input logic act, input logic [31:0] pix);
    if (!steady && frame_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    {alpha, blue, green, red} <= pix;
    do @(posedge clk); while (in_stall);
    transfers++;
  endtask

  // wait until every predicted pixel has come out and the pipeline is quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // dimensions carry random upper data bits, which the registers drop
  task automatic program_frame(input logic [DIM_BITS-1:0] w_reg, input logic [DIM_BITS-1:0] h_reg,
                               input logic [PIXEL_BITS-1:0] colour);
    logic [31:0] upper;
    upper = $urandom;
    write_reg(REG_FRAME_WIDTH, {upper[31:DIM_BITS], w_reg});
    upper = $urandom;
    write_reg(REG_FRAME_HEIGHT, {upper[31:DIM_BITS], h_reg});
    write_reg(REG_OUTLINE_COLOR, colour);
    cfg_write <= 1'b0;
  endtask

  // random pixel, opaque with the given percentage
  function automatic logic [31:0] random_pixel(input int unsigned density);
    logic [31:0] pix;
    pix = $urandom;
    if ($urandom_range(0, 99) >= density) pix[31:24] = 8'h00;
    else if ($urandom_range(0, 3) == 0) pix[31:24] = 8'hFF;
    else pix[31:24] = $urandom_range(1, 255);
    return pix;
  endfunction

  // one whole frame: pixels, then the flushes that drain it, with optional strays
  task automatic run_frame(input logic [DIM_BITS-1:0] w_reg, input logic [DIM_BITS-1:0] h_reg,
                           input logic [PIXEL_BITS-1:0] colour, input int unsigned density,
                           input bit counted, input bit noisy);
    int unsigned w, h;
    settle();
    program_frame(w_reg, h_reg, colour);
    w = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    h = (h_reg == 0) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
    frame_gaps = ($urandom_range(0, 3) != 0);
    mid_frame = 1'b1;
    for (int unsigned i = 0; i < w * h; i++) begin
      // stray flush before the frame is complete
      if (noisy && $urandom_range(0, 19) == 0) offer(ACTION_FLUSH, $urandom);
      offer(ACTION_PIXEL, random_pixel(density));
      if (counted) random_items++;
    end
    mid_frame = 1'b0;
    for (int unsigned i = 0; i <= w; i++) begin
      // stray pixel while the frame drains
      if (noisy && $urandom_range(0, 9) == 0) offer(ACTION_PIXEL, random_pixel(50));
      offer(ACTION_FLUSH, $urandom);
      if (counted) random_items++;
    end
    // flush with nothing pending
    if (noisy && $urandom_range(0, 4) == 0) offer(ACTION_FLUSH, $urandom);
    frames++;
  endtask

  initial begin : stimulus
    logic [31:0]         probe [9];
    logic [DIM_BITS-1:0] w_reg, h_reg;
    logic [31:0]         colour;
    int unsigned         density;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // opaque centre with a faint opaque corner: edge neighbours get the outline,
    // the other corners pass through
    probe = '{32'h0000_0000, 32'h00FF_FFFF, 32'h0012_3456,
              32'h00AB_CDEF, 32'hFF00_0000, 32'h00FF_FFFF,
              32'h00A5_A5A5, 32'h005A_5A5A, 32'h01FF_FFFF};
    write_reg(REG_UNMAPPED, $urandom);
    program_frame(13'd3, 13'd3, 32'h2040_C080);
    offer(ACTION_FLUSH, $urandom);
    for (int i = 0; i < 9; i++) begin
      offer(ACTION_PIXEL, probe[i]);
      if (i == 4) offer(ACTION_FLUSH, 32'hFFFF_FFFF);
    end
    for (int i = 0; i < 4; i++) begin
      if (i == 2) offer(ACTION_PIXEL, 32'hFFFF_FFFF);
      offer(ACTION_FLUSH, 32'h0000_0000);
    end

    // zero width and height act as a single pixel frame
    settle();
    program_frame('0, '0, 32'hFFFF_FFFF);
    offer(ACTION_PIXEL, 32'h00FF_00FF);
    offer(ACTION_FLUSH, $urandom);
    offer(ACTION_FLUSH, $urandom);

    // random frames, mostly small, with one full-width and one full-height frame
    while (random_items < RANDOM_ITEMS) begin
      steady = (random_items >= STEADY_FROM);
      density = densities[$urandom_range(0, 5)];
      if (frames == 4) begin
        run_frame(13'h1FFF, 13'd1, $urandom, density, 1'b0, 1'b1);
      end else if (frames == 7) begin
        run_frame(13'd1, 13'h1FFF, $urandom, density, 1'b0, 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w_reg = $urandom_range(0, 1);
            h_reg = $urandom_range(1, 8);
          end
          1: begin
            w_reg = $urandom_range(1, 12);
            h_reg = $urandom_range(0, 1);
          end
          2, 3: begin
            w_reg = $urandom_range(13, 40);
            h_reg = $urandom_range(1, 4);
          end
          default: begin
            w_reg = $urandom_range(2, 12);
            h_reg = $urandom_range(2, 8);
          end
        endcase
        case ($urandom_range(0, 7))
          0: colour = '0;
          1: colour = '1;
          default: colour = $urandom;
        endcase
        run_frame(w_reg, h_reg, colour, density, 1'b1, $urandom_range(0, 2) == 0);
      end
    end

    settle();
    $display("covered %0d frames in %0d input transfers, %0d filtered pixels compared",
             frames + 2, transfers, compared);
    $display("sizes from one pixel up to full row and column, stray flushes and pixels, stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
